>>> rtl/core/miwu_pkg.sv
// Package: shared widths, codes, coefficient bundle and Q8.24 arithmetic helpers
package miwu_pkg;

  localparam int IDX_W        = 10;
  localparam int Q_W          = 32;
  localparam int FRAC_W       = 24;
  localparam int PAR_W        = 31;
  localparam int DECAY_W      = 25;
  localparam int MODE_W       = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int IN_DATA_W    = 112;
  localparam int OUT_DATA_W   = 48;
  localparam int ELEMENTS_DEF = 1024;

  // Integrator modes
  localparam logic [MODE_W-1:0] MODE_VERLET     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VEL_VERLET = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LANGEVIN   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_MASS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_SCALE = 3'd4;

  localparam logic signed [63:0] Q_MAX  = 64'sd2147483647;
  localparam logic signed [63:0] Q_MIN  = -64'sd2147483648;
  localparam logic signed [63:0] Q_HALF = 64'sd1 <<< (FRAC_W - 1);

  typedef logic signed [Q_W-1:0] q_t;
  typedef logic signed [63:0]    prod_t;

  // Coefficients derived from the step and mass registers
  typedef struct packed {
    logic [PAR_W-1:0] kick;
    logic [PAR_W-1:0] c_verlet;
    logic [PAR_W-1:0] c_vv;
  } coef_t;

  // Clamp a wide value to the signed 32-bit range
  function automatic q_t sat32(input prod_t x);
    q_t r;
    if (x > Q_MAX) begin
      r = q_t'(Q_MAX);
    end else if (x < Q_MIN) begin
      r = q_t'(Q_MIN);
    end else begin
      r = q_t'(x);
    end
    return r;
  endfunction

  // Exact product of a signed value and a non-negative coefficient
  function automatic prod_t qmul_prod(input q_t a, input logic [PAR_W-1:0] b);
    q_t    bs;
    prod_t r;
    bs = $signed({1'b0, b});
    r  = a * bs;
    return r;
  endfunction

  // Round half up to Q8.24 and saturate
  function automatic q_t q_round(input prod_t p);
    prod_t t;
    t = (p + Q_HALF) >>> FRAC_W;
    return sat32(t);
  endfunction

endpackage

>>> rtl/core/miwu_coef.sv
// Coefficient unit: two registered stages that derive kick and position coefficients
module miwu_coef (
  input  logic                          clk,
  input  logic [miwu_pkg::PAR_W-1:0]    step_dt,
  input  logic [miwu_pkg::PAR_W-1:0]    inv_mass,
  output miwu_pkg::coef_t               coef
);

  logic [miwu_pkg::PAR_W-1:0] hdt;
  miwu_pkg::q_t               dt_s;
  miwu_pkg::q_t               dd_nxt;
  miwu_pkg::q_t               hd_nxt;
  miwu_pkg::q_t               kick_nxt;
  miwu_pkg::q_t               cv_nxt;
  miwu_pkg::q_t               cvv_nxt;
  logic [miwu_pkg::PAR_W-1:0] dd_r;
  logic [miwu_pkg::PAR_W-1:0] hd_r;
  logic [miwu_pkg::PAR_W-1:0] kick_r;
  miwu_pkg::coef_t            coef_r;

  assign hdt  = step_dt >> 1;
  assign dt_s = $signed({1'b0, step_dt});

  // First products: dt*dt, dt/2*dt, dt/2*(1/m); then scale by 1/m
  always_comb begin
    dd_nxt   = miwu_pkg::q_round(miwu_pkg::qmul_prod(dt_s, step_dt));
    hd_nxt   = miwu_pkg::q_round(miwu_pkg::qmul_prod(dt_s, hdt));
    kick_nxt = miwu_pkg::q_round(miwu_pkg::qmul_prod($signed({1'b0, hdt}), inv_mass));
    cv_nxt   = miwu_pkg::q_round(miwu_pkg::qmul_prod($signed({1'b0, dd_r}), inv_mass));
    cvv_nxt  = miwu_pkg::q_round(miwu_pkg::qmul_prod($signed({1'b0, hd_r}), inv_mass));
  end

  // Results are never negative, so the low 31 bits hold them
  always_ff @(posedge clk) begin
    dd_r            <= dd_nxt[miwu_pkg::PAR_W-1:0];
    hd_r            <= hd_nxt[miwu_pkg::PAR_W-1:0];
    kick_r          <= kick_nxt[miwu_pkg::PAR_W-1:0];
    coef_r.kick     <= kick_r;
    coef_r.c_verlet <= cv_nxt[miwu_pkg::PAR_W-1:0];
    coef_r.c_vv     <= cvv_nxt[miwu_pkg::PAR_W-1:0];
  end

  assign coef = coef_r;

endmodule

>>> rtl/core/md_integrator_weight_update_unit.sv
// Top level: pipelined Verlet / velocity Verlet / Langevin weight integrator
//
// Channels: in_* carries one element per transfer (index, position, gradient,
// noise sample in tdata, end-of-sweep mark in tlast); out_* returns the new
// position and the element index. cfg_* writes the five control registers;
// cfg_ready is always high. Write configuration only while no item is in flight.
// Throughput: one element per cycle while no result is held and no repeated index
// waits. An element whose store address matches one of the seven elements between
// memory read and write-back waits at the address stage until that write completes.
// From the input transfer to out_tvalid an element passes the address stage,
// store read, operand select, three multiply stages (the first two each followed
// by a round/add stage) and the output register, which takes the last round/add.
// Reset: configuration registers and valid bits go to zero, parity to even,
// first-sweep flag set. The velocity store is then cleared one entry per cycle,
// all entries, in_tready low; configuration writes are taken during that pass.
// When out_tready is low with a result waiting, the whole pipeline holds; a new
// element is still taken while the address stage is empty.
module md_integrator_weight_update_unit #(
  parameter int ELEMENTS = miwu_pkg::ELEMENTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: element_index[9:0], position[41:10], gradient_value[73:42],
  //           noise_sample[105:74], zero pad [111:106]
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [miwu_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                in_tlast,
  // out_tdata: new_position[31:0], result_index[41:32], zero pad [47:42]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [miwu_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [miwu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [miwu_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int IDX_W = miwu_pkg::IDX_W;
  localparam int PAR_W = miwu_pkg::PAR_W;
  localparam int AW    = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

  typedef logic signed [33:0] base_t;

  // Configuration registers
  logic [miwu_pkg::MODE_W-1:0]  mode_r;
  logic [PAR_W-1:0]             dt_r;
  logic [PAR_W-1:0]             inv_mass_r;
  logic [miwu_pkg::DECAY_W-1:0] decay_r;
  logic [PAR_W-1:0]             noise_r;
  logic [PAR_W-1:0]             hdt;
  miwu_pkg::coef_t              coef;

  logic is_verlet, is_vv, is_lang;

  // Sweep state and clearing pass
  logic          sweep_odd_r, first_sweep_r;
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  // Handshake and pipeline control
  logic            in_acc, adv, hazard, s1_go, wr_go;
  logic [IDX_W-1:0] in_idx;
  logic [AW-1:0]   in_addr;

  // Stage 1: address
  logic             s1_v_r, s1_odd_r, s1_first_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic [AW-1:0]    s1_addr_r;
  miwu_pkg::q_t     s1_pos_r, s1_grad_r, s1_noise_r;

  // Stage 2: store read data
  logic             s2_v_r, s2_odd_r, s2_first_r;
  logic [IDX_W-1:0] s2_idx_r;
  logic [AW-1:0]    s2_addr_r;
  miwu_pkg::q_t     s2_pos_r, s2_grad_r, s2_noise_r, vel_rd_r, prv_rd_r;

  // Stage 3: operands
  logic             s3_v_r, s3_odd_r;
  logic [IDX_W-1:0] s3_idx_r;
  logic [AW-1:0]    s3_addr_r;
  miwu_pkg::q_t     s3_pos_r, s3_grad_r, s3_noise_r, s3_vel_r, s3_opk_r, s3_pwd_r;
  base_t            s3_base_r;
  miwu_pkg::q_t     s3_opk_nxt, s3_prev_sel;
  base_t            s3_base_nxt;

  // Stage 4: first products
  logic             s4_v_r, s4_odd_r;
  logic [IDX_W-1:0] s4_idx_r;
  logic [AW-1:0]    s4_addr_r;
  miwu_pkg::q_t     s4_pos_r, s4_vel_r, s4_pwd_r;
  base_t            s4_base_r;
  miwu_pkg::prod_t  s4_pk_r, s4_pc_r, s4_pvdt_r, s4_pn_r;
  logic [PAR_W-1:0] c_sel;

  // Stage 5: kicked velocity, simple results
  logic             s5_v_r, s5_odd_r;
  logic [IDX_W-1:0] s5_idx_r;
  logic [AW-1:0]    s5_addr_r;
  miwu_pkg::q_t     s5_pos_r, s5_pwd_r, s5_v1_r, s5_resa_r, s5_qn_r;
  miwu_pkg::q_t     s5_v1_nxt, s5_resa_nxt, s5_qc, s5_qvdt;

  // Stage 6: second products
  logic             s6_v_r, s6_odd_r;
  logic [IDX_W-1:0] s6_idx_r;
  logic [AW-1:0]    s6_addr_r;
  miwu_pkg::q_t     s6_pos_r, s6_pwd_r, s6_v1_r, s6_resa_r, s6_qn_r;
  miwu_pkg::prod_t  s6_p1h_r, s6_p1d_r;

  // Stage 7: half-drifted position, damped velocity
  logic             s7_v_r, s7_odd_r;
  logic [IDX_W-1:0] s7_idx_r;
  logic [AW-1:0]    s7_addr_r;
  miwu_pkg::q_t     s7_pwd_r, s7_v1_r, s7_resa_r, s7_p1_r, s7_v2_r;

  // Stage 8: third product, write-back
  logic             s8_v_r, s8_odd_r;
  logic [IDX_W-1:0] s8_idx_r;
  logic [AW-1:0]    s8_addr_r;
  miwu_pkg::q_t     s8_pwd_r, s8_v1_r, s8_resa_r, s8_p1_r, s8_v2_r;
  miwu_pkg::prod_t  s8_p2h_r;
  miwu_pkg::q_t     res_nxt;

  // Output register
  logic             out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  miwu_pkg::q_t     out_pos_r;

  // Stores
  miwu_pkg::q_t vel_mem [ELEMENTS];
  miwu_pkg::q_t prv_mem [ELEMENTS];
  logic          vel_we, prv_we, vel_upd_v1, vel_upd_v2;
  logic [AW-1:0] vel_waddr;
  miwu_pkg::q_t  vel_wdata;

  // Coefficients follow the step and mass registers, registered in miwu_coef
  miwu_coef u_coef (
    .clk      (clk),
    .step_dt  (dt_r),
    .inv_mass (inv_mass_r),
    .coef     (coef)
  );

  assign hdt       = dt_r >> 1;
  assign is_verlet = (mode_r == miwu_pkg::MODE_VERLET);
  assign is_vv     = (mode_r == miwu_pkg::MODE_VEL_VERLET);
  assign is_lang   = (mode_r == miwu_pkg::MODE_LANGEVIN);

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= '0;
      dt_r       <= '0;
      inv_mass_r <= '0;
      decay_r    <= '0;
      noise_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        miwu_pkg::REG_MODE:        mode_r     <= cfg_data[miwu_pkg::MODE_W-1:0];
        miwu_pkg::REG_STEP_DT:     dt_r       <= cfg_data[PAR_W-1:0];
        miwu_pkg::REG_INV_MASS:    inv_mass_r <= cfg_data[PAR_W-1:0];
        miwu_pkg::REG_DECAY:       decay_r    <= cfg_data[miwu_pkg::DECAY_W-1:0];
        miwu_pkg::REG_NOISE_SCALE: noise_r    <= cfg_data[PAR_W-1:0];
        default: ;
      endcase
    end
  end

  // Store address: index folded into the store depth
  assign in_idx = in_tdata[IDX_W-1:0];

  generate
    if (ELEMENTS >= (1 << IDX_W)) begin : g_addr_direct
      assign in_addr = AW'(in_idx);
    end else begin : g_addr_mod
      localparam int RECIP_SH = 2 * IDX_W;
      localparam int PROD_W   = RECIP_SH + IDX_W;
      localparam int RECIP    = (1 << RECIP_SH) / ELEMENTS;
      logic [PROD_W-1:0]  mod_prod;
      logic [IDX_W-1:0]   mod_quo;
      logic [2*IDX_W-1:0] mod_back;
      logic [IDX_W:0]     mod_rem;
      // Reciprocal estimate is low by at most one; one subtract corrects it
      always_comb begin
        mod_prod = PROD_W'(in_idx) * PROD_W'(RECIP);
        mod_quo  = IDX_W'(mod_prod >> RECIP_SH);
        mod_back = (2 * IDX_W)'(mod_quo) * (2 * IDX_W)'(ELEMENTS);
        mod_rem  = (IDX_W + 1)'(in_idx) - (IDX_W + 1)'(mod_back);
        if (mod_rem >= (IDX_W + 1)'(ELEMENTS)) begin
          in_addr = AW'(mod_rem - (IDX_W + 1)'(ELEMENTS));
        end else begin
          in_addr = AW'(mod_rem);
        end
      end
    end
  endgenerate

  // Pipeline control: hold everything while a result waits; hold the address
  // stage while an older element of the same address has not written back
  assign adv    = !out_valid_r || out_tready;
  assign hazard = (s2_v_r && (s2_addr_r == s1_addr_r)) ||
                  (s3_v_r && (s3_addr_r == s1_addr_r)) ||
                  (s4_v_r && (s4_addr_r == s1_addr_r)) ||
                  (s5_v_r && (s5_addr_r == s1_addr_r)) ||
                  (s6_v_r && (s6_addr_r == s1_addr_r)) ||
                  (s7_v_r && (s7_addr_r == s1_addr_r)) ||
                  (s8_v_r && (s8_addr_r == s1_addr_r));
  assign s1_go     = adv && !hazard;
  assign in_tready = !clr_busy_r && (!s1_v_r || s1_go);
  assign in_acc    = in_tvalid && in_tready;
  assign wr_go     = adv && s8_v_r;

  // Sweep parity, first-sweep flag and velocity clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_odd_r   <= 1'b0;
      first_sweep_r <= 1'b1;
      clr_busy_r    <= 1'b1;
      clr_addr_r    <= '0;
    end else begin
      if (in_acc && in_tlast) begin
        sweep_odd_r   <= !sweep_odd_r;
        first_sweep_r <= 1'b0;
      end
      if (clr_busy_r) begin
        if (clr_addr_r == AW'(ELEMENTS - 1)) begin
          clr_busy_r <= 1'b0;
        end else begin
          clr_addr_r <= clr_addr_r + 1'b1;
        end
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      s6_v_r      <= 1'b0;
      s7_v_r      <= 1'b0;
      s8_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        s2_v_r      <= s1_v_r && !hazard;
        s3_v_r      <= s2_v_r;
        s4_v_r      <= s3_v_r;
        s5_v_r      <= s4_v_r;
        s6_v_r      <= s5_v_r;
        s7_v_r      <= s6_v_r;
        s8_v_r      <= s7_v_r;
        out_valid_r <= s8_v_r;
      end
    end
  end

  // Capture the element with the sweep state it belongs to
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_idx_r   <= in_idx;
      s1_addr_r  <= in_addr;
      s1_pos_r   <= in_tdata[41:10];
      s1_grad_r  <= in_tdata[73:42];
      s1_noise_r <= in_tdata[105:74];
      s1_odd_r   <= sweep_odd_r;
      s1_first_r <= first_sweep_r;
    end
  end

  // Operand select: pre-added gradient for the velocity Verlet kick,
  // exact 2*pos - prev for Verlet, value kept in the previous store
  always_comb begin
    s3_opk_nxt  = is_vv ? miwu_pkg::sat32(64'(prv_rd_r) + 64'(s2_grad_r)) : s2_grad_r;
    s3_prev_sel = s2_first_r ? s2_pos_r : prv_rd_r;
    s3_base_nxt = base_t'(s2_pos_r) + base_t'(s2_pos_r) - base_t'(s3_prev_sel);
  end

  assign c_sel = is_verlet ? coef.c_verlet : coef.c_vv;

  // Round, then kick velocity and form Verlet / velocity Verlet positions
  always_comb begin
    s5_qc     = miwu_pkg::q_round(s4_pc_r);
    s5_qvdt   = miwu_pkg::q_round(s4_pvdt_r);
    s5_v1_nxt = miwu_pkg::sat32(64'(s4_vel_r) - 64'(miwu_pkg::q_round(s4_pk_r)));
    if (is_verlet) begin
      s5_resa_nxt = miwu_pkg::sat32(64'(s4_base_r) - 64'(s5_qc));
    end else if (is_vv && !s4_odd_r) begin
      s5_resa_nxt = miwu_pkg::sat32(64'(s4_pos_r) + 64'(s5_qvdt) - 64'(s5_qc));
    end else begin
      s5_resa_nxt = s4_pos_r;
    end
  end

  // Final Langevin drift or the result formed earlier
  always_comb begin
    if (is_lang && !s8_odd_r) begin
      res_nxt = miwu_pkg::sat32(64'(s8_p1_r) + 64'(miwu_pkg::q_round(s8_p2h_r)));
    end else begin
      res_nxt = s8_resa_r;
    end
  end

  // Payload pipeline, advanced together
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_idx_r   <= s1_idx_r;
      s2_addr_r  <= s1_addr_r;
      s2_pos_r   <= s1_pos_r;
      s2_grad_r  <= s1_grad_r;
      s2_noise_r <= s1_noise_r;
      s2_odd_r   <= s1_odd_r;
      s2_first_r <= s1_first_r;

      s3_idx_r   <= s2_idx_r;
      s3_addr_r  <= s2_addr_r;
      s3_pos_r   <= s2_pos_r;
      s3_grad_r  <= s2_grad_r;
      s3_noise_r <= s2_noise_r;
      s3_odd_r   <= s2_odd_r;
      s3_vel_r   <= vel_rd_r;
      s3_opk_r   <= s3_opk_nxt;
      s3_base_r  <= s3_base_nxt;
      s3_pwd_r   <= is_verlet ? s2_pos_r : s2_grad_r;

      s4_idx_r   <= s3_idx_r;
      s4_addr_r  <= s3_addr_r;
      s4_pos_r   <= s3_pos_r;
      s4_odd_r   <= s3_odd_r;
      s4_vel_r   <= s3_vel_r;
      s4_base_r  <= s3_base_r;
      s4_pwd_r   <= s3_pwd_r;
      s4_pk_r    <= miwu_pkg::qmul_prod(s3_opk_r, coef.kick);
      s4_pc_r    <= miwu_pkg::qmul_prod(s3_grad_r, c_sel);
      s4_pvdt_r  <= miwu_pkg::qmul_prod(s3_vel_r, dt_r);
      s4_pn_r    <= miwu_pkg::qmul_prod(s3_noise_r, noise_r);

      s5_idx_r   <= s4_idx_r;
      s5_addr_r  <= s4_addr_r;
      s5_pos_r   <= s4_pos_r;
      s5_odd_r   <= s4_odd_r;
      s5_pwd_r   <= s4_pwd_r;
      s5_v1_r    <= s5_v1_nxt;
      s5_resa_r  <= s5_resa_nxt;
      s5_qn_r    <= miwu_pkg::q_round(s4_pn_r);

      s6_idx_r   <= s5_idx_r;
      s6_addr_r  <= s5_addr_r;
      s6_pos_r   <= s5_pos_r;
      s6_odd_r   <= s5_odd_r;
      s6_pwd_r   <= s5_pwd_r;
      s6_v1_r    <= s5_v1_r;
      s6_resa_r  <= s5_resa_r;
      s6_qn_r    <= s5_qn_r;
      s6_p1h_r   <= miwu_pkg::qmul_prod(s5_v1_r, hdt);
      s6_p1d_r   <= miwu_pkg::qmul_prod(s5_v1_r, PAR_W'(decay_r));

      s7_idx_r   <= s6_idx_r;
      s7_addr_r  <= s6_addr_r;
      s7_odd_r   <= s6_odd_r;
      s7_pwd_r   <= s6_pwd_r;
      s7_v1_r    <= s6_v1_r;
      s7_resa_r  <= s6_resa_r;
      s7_p1_r    <= miwu_pkg::sat32(64'(s6_pos_r) + 64'(miwu_pkg::q_round(s6_p1h_r)));
      s7_v2_r    <= miwu_pkg::sat32(64'(miwu_pkg::q_round(s6_p1d_r)) + 64'(s6_qn_r));

      s8_idx_r   <= s7_idx_r;
      s8_addr_r  <= s7_addr_r;
      s8_odd_r   <= s7_odd_r;
      s8_pwd_r   <= s7_pwd_r;
      s8_v1_r    <= s7_v1_r;
      s8_resa_r  <= s7_resa_r;
      s8_p1_r    <= s7_p1_r;
      s8_v2_r    <= s7_v2_r;
      s8_p2h_r   <= miwu_pkg::qmul_prod(s7_v2_r, hdt);

      out_idx_r  <= s8_idx_r;
      out_pos_r  <= res_nxt;
    end
  end

  // Write-back as the element leaves the last stage
  assign vel_upd_v1 = (is_vv || is_lang) && s8_odd_r;
  assign vel_upd_v2 = is_lang && !s8_odd_r;
  assign prv_we     = wr_go && (is_verlet || (is_vv && !s8_odd_r));
  assign vel_we     = clr_busy_r || (wr_go && (vel_upd_v1 || vel_upd_v2));
  assign vel_waddr  = clr_busy_r ? clr_addr_r : s8_addr_r;
  assign vel_wdata  = clr_busy_r ? '0 : (vel_upd_v2 ? s8_v2_r : s8_v1_r);

  // Velocity store
  always_ff @(posedge clk) begin
    if (vel_we) begin
      vel_mem[vel_waddr] <= vel_wdata;
    end
    if (adv) begin
      vel_rd_r <= vel_mem[s1_addr_r];
    end
  end

  // Previous-position / cached-gradient store
  always_ff @(posedge clk) begin
    if (prv_we) begin
      prv_mem[s8_addr_r] <= s8_pwd_r;
    end
    if (adv) begin
      prv_rd_r <= prv_mem[s1_addr_r];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = miwu_pkg::OUT_DATA_W'({out_idx_r, out_pos_r});

endmodule

>>> rtl/core/miwu_checker.sv
// Port checker for the integrator top level, attached by bind
module miwu_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [miwu_pkg::IN_DATA_W-1:0]    in_tdata,
  input logic                              in_tlast,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [miwu_pkg::OUT_DATA_W-1:0]   out_tdata,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [miwu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input logic [miwu_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Hold a stalled result and its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  // Clearing pass blocks input right after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input taken during velocity clear");

  // Configuration is always taken
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration transfer refused");

endmodule

bind md_integrator_weight_update_unit miwu_checker u_miwu_checker (.*);

>>> verif/tb_md_integrator_weight_update_unit.sv
// Testbench for the weight integrator: directed table plus random sweeps, scoreboard on results
module tb_md_integrator_weight_update_unit;
  import miwu_pkg::*;

  localparam int                 CLK_HALF      = 6;
  localparam int                 RANDOM_ITEMS  = 1750;
  localparam int                 SETTLE_CYCLES = 12;
  localparam int                 DRAIN_LIMIT   = 20000;
  localparam int unsigned        CYCLE_LIMIT   = 400000;
  localparam int                 PRINT_CAP     = 40;
  localparam logic [MODE_W-1:0]  MODE_UNUSED   = 2'd3;
  localparam logic signed [63:0] FIX_HI        = 64'sd2147483647;
  localparam logic signed [63:0] FIX_LO        = -64'sd2147483648;
  localparam logic signed [63:0] FIX_ROUND     = 64'sd8388608;

  // One element as it enters the block
  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic signed [31:0] pos;
    logic signed [31:0] grad;
    logic signed [31:0] noise;
    logic               last;
  } elem_t;

  // One updated position as it leaves the block
  typedef struct {
    logic [31:0]      new_pos;
    logic [IDX_W-1:0] idx;
  } position_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [31:0]       dt;
    logic [31:0]       inv_mass;
    logic [31:0]       decay;
    logic [31:0]       noise_scale;
  } settings_t;

  typedef struct packed {
    logic [3:0]       phase;
    logic [IDX_W-1:0] idx;
    logic [31:0]      pos;
    logic [31:0]      grad;
    logic [31:0]      noise;
    logic             last;
    logic             typed;
    logic [31:0]      want_pos;
  } dir_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  md_integrator_weight_update_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Shadow of the integrator state and registers
  logic [MODE_W-1:0]  shadow_mode;
  logic signed [63:0] shadow_dt;
  logic signed [63:0] shadow_inv_mass;
  logic signed [63:0] shadow_decay;
  logic signed [63:0] shadow_noise_scale;
  logic signed [31:0] prev_mem [ELEMENTS_DEF];
  bit                 prev_written [ELEMENTS_DEF];
  logic signed [31:0] vel_mem [ELEMENTS_DEF];
  bit                 sweep_odd;
  bit                 first_sweep;
  logic [IDX_W-1:0]   written_idx [$];

  position_t   pending_positions [$];
  int          mismatch_count = 0;
  int          results_checked = 0;
  int unsigned cycle_count = 0;
  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;

  // Directed settings, indexed by the phase column of the table; phase 0 is reset
  settings_t dir_settings [7] = '{
    '{MODE_VERLET,     32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
    '{MODE_VERLET,     32'h0100_0000, 32'h0100_0000, 32'h0000_0000, 32'h0000_0000},
    '{MODE_VERLET,     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0100_0000, 32'h7FFF_FFFF},
    '{MODE_VEL_VERLET, 32'h0080_0000, 32'h0200_0000, 32'h0000_0000, 32'h0000_0000},
    '{MODE_LANGEVIN,   32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0080_0000},
    '{MODE_LANGEVIN,   32'h7FFF_FFFF, 32'h0040_0000, 32'h01FF_FFFF, 32'h7FFF_FFFF},
    '{MODE_UNUSED,     32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}
  };

  // phase, index, position, gradient, noise, end of sweep, typed, expected position
  dir_row_t dir_rows [23] = '{
    // first Verlet sweep at reset settings: position passes through
    '{4'd0, 10'd0,    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b1, 32'h7FFF_FFFF},
    '{4'd0, 10'd1023, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h8000_0000},
    '{4'd0, 10'd5,    32'h0100_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h0100_0000},
    // Verlet with stored previous positions, saturating both ways
    '{4'd1, 10'd5,    32'h0200_0000, 32'h0080_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{4'd1, 10'd0,    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{4'd1, 10'd1023, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
    '{4'd2, 10'd5,    32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
    // velocity Verlet entered on an odd sweep, then even and odd
    '{4'd3, 10'd5,    32'h0000_0000, 32'hFF00_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
    '{4'd3, 10'd5,    32'h0100_0000, 32'h0040_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{4'd3, 10'd1023, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{4'd3, 10'd0,    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
    '{4'd3, 10'd5,    32'h0100_0000, 32'h0040_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{4'd3, 10'd1023, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
    // Langevin V-R-O-R sweep with a repeated index, then V sweep
    '{4'd4, 10'd5,    32'h0100_0000, 32'h0020_0000, 32'h0100_0000, 1'b0, 1'b0, 32'h0},
    '{4'd4, 10'd7,    32'hFF00_0000, 32'h0000_0000, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{4'd4, 10'd5,    32'h0100_0000, 32'hFFE0_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0},
    '{4'd4, 10'd5,    32'h0000_0000, 32'h0010_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{4'd4, 10'd7,    32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
    // Langevin with decay above one and maximal step and noise scale
    '{4'd5, 10'd5,    32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{4'd5, 10'd7,    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, 32'h0},
    '{4'd5, 10'd5,    32'h8000_0000, 32'h0000_0001, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
    // unused mode: position passes through, stores untouched
    '{4'd6, 10'd9,    32'h1234_5678, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 32'h1234_5678},
    '{4'd6, 10'd1023, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h8000_0000}
  };

  // Clock
  initial begin
    forever begin
      #CLK_HALF clk = ~clk;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_positions.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
    end
  endtask

  // Compare each result transfer with the oldest pending position
  always @(posedge clk) begin
    position_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_positions.size() == 0) begin
        report_mismatch($sformatf("unexpected result pos=%h idx=%0d",
                                  out_tdata[31:0], out_tdata[41:32]));
      end else begin
        want = pending_positions.pop_front();
        results_checked++;
        if (out_tdata[31:0] !== want.new_pos) begin
          report_mismatch($sformatf("idx %0d new_position got %h want %h",
                                    want.idx, out_tdata[31:0], want.new_pos));
        end
        if (out_tdata[41:32] !== want.idx) begin
          report_mismatch($sformatf("result_index got %0d want %0d",
                                    out_tdata[41:32], want.idx));
        end
      end
    end
  end

  // Q8.24 arithmetic for the prediction
  function automatic logic signed [63:0] clamp(input logic signed [63:0] x);
    if (x > FIX_HI) return FIX_HI;
    if (x < FIX_LO) return FIX_LO;
    return x;
  endfunction

  function automatic logic signed [63:0] fixmul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [63:0] prod;
    prod = a * b + FIX_ROUND;
    return clamp(prod >>> FRAC_W);
  endfunction

  function automatic void mark_written(input logic [IDX_W-1:0] a);
    if (!prev_written[a]) begin
      prev_written[a] = 1'b1;
      written_idx.push_back(a);
    end
  endfunction

  // Advance the shadow state by one element and return its updated position;
  // the store address equals the index since the depth covers all 10 bits
  function automatic position_t integrate_elem(input elem_t e);
    logic signed [63:0] p, g, n, v, prv, hdt, kick, c, v1, p1, v2, nxt;
    logic [IDX_W-1:0]   a;
    position_t          r;
    a    = e.idx;
    p    = e.pos;
    g    = e.grad;
    n    = e.noise;
    v    = vel_mem[a];
    prv  = prev_mem[a];
    hdt  = shadow_dt >>> 1;
    kick = fixmul(hdt, shadow_inv_mass);
    nxt  = p;
    case (shadow_mode)
      MODE_VERLET: begin
        if (first_sweep) prv = p;
        c   = fixmul(fixmul(shadow_dt, shadow_dt), shadow_inv_mass);
        nxt = clamp(2 * p - prv - fixmul(g, c));
        prev_mem[a] = e.pos;
        mark_written(a);
      end
      MODE_VEL_VERLET: begin
        if (!sweep_odd) begin
          c   = fixmul(fixmul(hdt, shadow_dt), shadow_inv_mass);
          nxt = clamp(p + fixmul(v, shadow_dt) - fixmul(g, c));
          prev_mem[a] = e.grad;
          mark_written(a);
        end else begin
          vel_mem[a] = 32'(clamp(v - fixmul(clamp(prv + g), kick)));
        end
      end
      MODE_LANGEVIN: begin
        if (!sweep_odd) begin
          v1  = clamp(v - fixmul(g, kick));
          p1  = clamp(p + fixmul(v1, hdt));
          v2  = clamp(fixmul(v1, shadow_decay) + fixmul(n, shadow_noise_scale));
          nxt = clamp(p1 + fixmul(v2, hdt));
          vel_mem[a] = 32'(v2);
        end else begin
          vel_mem[a] = 32'(clamp(v - fixmul(g, kick)));
        end
      end
      default: ;
    endcase
    if (e.last) begin
      sweep_odd   = !sweep_odd;
      first_sweep = 1'b0;
    end
    r.new_pos = 32'(nxt);
    r.idx     = e.idx;
    return r;
  endfunction

  // True when this index would read a previous-store entry never written
  function automatic bit hits_unwritten(input logic [IDX_W-1:0] a);
    bit reads;
    reads = (shadow_mode == MODE_VERLET && !first_sweep) ||
            (shadow_mode == MODE_VEL_VERLET && sweep_odd);
    return reads && !prev_written[a];
  endfunction

  // Send one element, hold it until the transfer, then predict its result
  task automatic drive_elem(input elem_t e, input bit typed, input logic [31:0] want_pos);
    position_t r;
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, e.noise, e.grad, e.pos, e.idx};
    in_tlast  <= e.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = integrate_elem(e);
    if (typed) r.new_pos = want_pos;
    pending_positions.push_back(r);
  endtask

  // Hold off input until every pending position has come back, then settle
  task automatic drain_results();
    int waited;
    in_tvalid <= 1'b0;
    waited = 0;
    while (pending_positions.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_positions.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_positions.size()));
      pending_positions.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; the caller drops cfg_valid after its last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MODE:        shadow_mode        = val[MODE_W-1:0];
      REG_STEP_DT:     shadow_dt          = {33'b0, val[PAR_W-1:0]};
      REG_INV_MASS:    shadow_inv_mass    = {33'b0, val[PAR_W-1:0]};
      REG_DECAY:       shadow_decay       = {39'b0, val[DECAY_W-1:0]};
      REG_NOISE_SCALE: shadow_noise_scale = {33'b0, val[PAR_W-1:0]};
      default: ;
    endcase
  endtask

  task automatic load_settings(input settings_t s);
    write_reg(REG_MODE, {{(32-MODE_W){1'b0}}, s.mode});
    write_reg(REG_STEP_DT, s.dt);
    write_reg(REG_INV_MASS, s.inv_mass);
    write_reg(REG_DECAY, s.decay);
    write_reg(REG_NOISE_SCALE, s.noise_scale);
    cfg_valid <= 1'b0;
  endtask

  // Mostly moderate values, with extremes and full-range words mixed in
  function automatic logic [31:0] rand_fix();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0:       r = 32'h7FFF_FFFF;
      1:       r = 32'h8000_0000;
      2, 3:    ;
      default: r = {{5{r[26]}}, r[26:0]};
    endcase
    return r;
  endfunction

  function automatic settings_t random_settings();
    settings_t s;
    int        pick;
    pick   = $urandom_range(9);
    s.mode = (pick < 3) ? MODE_VERLET : (pick < 6) ? MODE_VEL_VERLET :
             (pick < 9) ? MODE_LANGEVIN : MODE_UNUSED;
    case ($urandom_range(7))
      0:       s.dt = 32'h0;
      1:       s.dt = 32'h7FFF_FFFF;
      default: s.dt = $urandom_range(0, 32'h0080_0000);
    endcase
    case ($urandom_range(7))
      0:       s.inv_mass = 32'h0;
      1:       s.inv_mass = 32'h7FFF_FFFF;
      default: s.inv_mass = $urandom_range(32'h0040_0000, 32'h0400_0000);
    endcase
    case ($urandom_range(7))
      0:       s.decay = 32'h0;
      1:       s.decay = 32'h0100_0000;
      2:       s.decay = 32'h01FF_FFFF;
      default: s.decay = $urandom_range(0, 32'h0100_0000);
    endcase
    case ($urandom_range(7))
      0:       s.noise_scale = 32'h0;
      1:       s.noise_scale = 32'h7FFF_FFFF;
      default: s.noise_scale = $urandom_range(0, 32'h0080_0000);
    endcase
    return s;
  endfunction

  initial begin
    elem_t            e;
    settings_t        s;
    logic [IDX_W-1:0] sweep_set [$];
    logic [IDX_W-1:0] base;
    int               cur_phase;
    int               rand_sent;
    int               phase_count;
    int               mode_phases [4];
    int               set_len;
    int               stride;
    int               n_sweeps;

    // Shadow state after reset
    shadow_mode        = MODE_VERLET;
    shadow_dt          = 0;
    shadow_inv_mass    = 0;
    shadow_decay       = 0;
    shadow_noise_scale = 0;
    sweep_odd          = 1'b0;
    first_sweep        = 1'b1;
    for (int i = 0; i < ELEMENTS_DEF; i++) begin
      prev_mem[i]     = '0;
      prev_written[i] = 1'b0;
      vel_mem[i]      = '0;
    end
    rand_sent   = 0;
    phase_count = 0;
    for (int i = 0; i < 4; i++) mode_phases[i] = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    cur_phase = 0;
    for (int k = 0; k < $size(dir_rows); k++) begin
      if (dir_rows[k].phase != cur_phase) begin
        drain_results();
        cur_phase = dir_rows[k].phase;
        load_settings(dir_settings[cur_phase]);
      end
      e.idx   = dir_rows[k].idx;
      e.pos   = $signed(dir_rows[k].pos);
      e.grad  = $signed(dir_rows[k].grad);
      e.noise = $signed(dir_rows[k].noise);
      e.last  = dir_rows[k].last;
      drive_elem(e, dir_rows[k].typed, dir_rows[k].want_pos);
    end

    // Random phases of whole sweeps over one index set per phase
    while (rand_sent < RANDOM_ITEMS) begin
      if (rand_sent < RANDOM_ITEMS / 3) begin
        send_gap_pct   = 32;
        recv_stall_pct = 84;
      end else if (rand_sent < 2 * RANDOM_ITEMS / 3) begin
        send_gap_pct   = 84;
        recv_stall_pct = 32;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      drain_results();
      s = random_settings();
      load_settings(s);
      phase_count++;
      mode_phases[s.mode]++;

      sweep_set.delete();
      set_len = $urandom_range(1, 20);
      base    = $urandom_range(1023);
      stride  = ($urandom_range(5) == 0) ? $urandom_range(2, 9) : 1;
      for (int k = 0; k < set_len; k++) begin
        if ($urandom_range(7) == 0) sweep_set.push_back($urandom_range(1023));
        else sweep_set.push_back(base + IDX_W'(k * stride));
      end

      n_sweeps = $urandom_range(2, 6);
      for (int sw = 0; sw < n_sweeps; sw++) begin
        for (int k = 0; k < set_len; k++) begin
          e.idx = sweep_set[k];
          if ($urandom_range(11) == 0) e.idx = sweep_set[$urandom_range(set_len - 1)];
          else if ($urandom_range(24) == 0) e.idx = $urandom_range(1023);
          // drop or add a sweep mark now and then
          e.last = (k == set_len - 1);
          if ($urandom_range(29) == 0) e.last = !e.last;
          if (hits_unwritten(e.idx)) begin
            e.idx = written_idx[$urandom_range(written_idx.size() - 1)];
          end
          e.pos   = $signed(rand_fix());
          e.grad  = $signed(rand_fix());
          e.noise = $signed(rand_fix());
          drive_elem(e, 1'b0, 32'h0);
          rand_sent++;
        end
      end
    end
    drain_results();

    $display("Checked %0d results: %0d directed elements, %0d random elements in %0d phases",
             results_checked, $size(dir_rows), rand_sent, phase_count);
    $display("Random phases per mode: Verlet %0d, velocity Verlet %0d, Langevin %0d, unused %0d",
             mode_phases[0], mode_phases[1], mode_phases[2], mode_phases[3]);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
